[rtl/quadratic_root_solver_defines.svh]
// Assertion macros for the quadratic root solver checker.
// Needs clk and rst_n in the scope of use.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// same-cycle implication
`define QRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrs check failed");

// next-cycle implication
`define QRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrs check failed");

`endif

[rtl/qrs_pkg.sv]
// Shared types and constants for the quadratic root solver.
// No dependencies.
package qrs_pkg;

    localparam int OUT_BITS        = 34;
    localparam int ZERO_BAND_SCALE = 1000000;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_DOUBLE  = 2'd1,
        KIND_REAL    = 2'd2,
        KIND_COMPLEX = 2'd3
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  neg1;
        logic  neg2;
    } fin_ctrl_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [OUT_BITS-1:0] second;
        logic signed [OUT_BITS-1:0] first;
    } result_t;

endpackage

[rtl/quadratic_root_solver.sv]
// Quadratic root solver top level: front end, square root, numerators,
// two dividers, finish. Depends on qrs_pkg and all qrs_* modules.
//
//  channel  dir  tdata (low bit up)                     tuser
//  s_axis   in   coef_a, coef_b, coef_c (byte padded)   -
//  m_axis   out  first_value, second_value (72 bits)    root_kind
//
// One beat per cycle while the skid stage is empty. Stages: three front
// stages, one per root bit in the square root, one numerator stage, one per
// quotient bit in the dividers, one output.
// All stages advance together; a stalled output fills the skid stage, and
// s_axis_tready falls only while it is full. Reset clears the valid bits.
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int COEF_BITS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // coef_a, coef_b, coef_c, zero fill
    input  logic [8*((3*COEF_BITS+7)/8)-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // first_value, second_value, zero fill
    output logic [8*((2*OUT_BITS+7)/8)-1:0]    m_axis_tdata,
    // root_kind
    output logic [1:0]                         m_axis_tuser
);

    localparam int SP   = COEF_BITS + 2 + FRAC_BITS;
    localparam int DW   = 2*(COEF_BITS + 2);
    localparam int KW   = COEF_BITS + FRAC_BITS + 1;
    localparam int MW   = COEF_BITS + 1;
    localparam int NW   = SP + 1;
    localparam int SW   = SP + 2;
    localparam int STW  = 3 + KW + MW;
    localparam int OTW  = 8*((2*OUT_BITS+7)/8);

    logic                 en;
    logic                 f_valid, f_aneg;
    logic [DW-1:0]        f_dabs;
    kind_t                f_kind;
    logic signed [KW-1:0] f_k;
    logic [MW-1:0]        f_m;

    logic                 s_valid, s_exact;
    logic [SP-1:0]        s_root;
    logic [STW-1:0]       s_tag;

    logic                 s_aneg;
    kind_t                s_kind;
    logic signed [KW-1:0] s_k;
    logic [MW-1:0]        s_m;

    logic signed [SW-1:0] kx, qx, inx, p_fl, p_cl, n_fl, n_cl, kabs;
    logic [NW-1:0]        n1_next, n2_next, n1_reg, n2_reg;
    logic                 neg1_next, neg2_next, neg1_reg, neg2_reg;
    logic                 nv_reg;
    kind_t                nk_reg;
    logic [MW-1:0]        nm_reg;

    logic                 d1_valid, d2_valid;
    logic [NW-1:0]        d1_quo, d2_quo;
    logic [2:0]           d1_tag, d2_tag;
    fin_ctrl_t            fctrl;
    result_t              res;

    qrs_disc #(
        .COEF_BITS (COEF_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid && en),
        .coef_a    (s_axis_tdata[COEF_BITS-1:0]),
        .coef_b    (s_axis_tdata[2*COEF_BITS-1:COEF_BITS]),
        .coef_c    (s_axis_tdata[3*COEF_BITS-1:2*COEF_BITS]),
        .out_valid (f_valid),
        .d_abs     (f_dabs),
        .kind      (f_kind),
        .a_neg     (f_aneg),
        .k_val     (f_k),
        .m_val     (f_m)
    );

    qrs_sqrt #(
        .SP        (SP),
        .FRAC_BITS (FRAC_BITS),
        .TW        (STW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .d_in      (f_dabs),
        .tag_in    ({f_aneg, f_kind, f_k, f_m}),
        .out_valid (s_valid),
        .root      (s_root),
        .exact     (s_exact),
        .tag_out   (s_tag)
    );

    always_comb
    begin
        s_m    = s_tag[MW-1:0];
        s_k    = s_tag[MW+KW-1:MW];
        s_kind = kind_t'(s_tag[MW+KW+1:MW+KW]);
        s_aneg = s_tag[STW-1];
        kx     = SW'(s_k);
        qx     = SW'({2'b00, s_root});
        inx    = SW'({1'b0, !s_exact});
        p_fl   = kx + qx;
        p_cl   = p_fl + inx;
        n_cl   = kx - qx;
        n_fl   = n_cl - inx;
        kabs   = kx[SW-1] ? -kx : kx;
        unique case (s_kind)
            KIND_REAL:
            begin
                if (!s_aneg)
                begin
                    neg1_next = p_fl[SW-1];
                    n1_next   = NW'(neg1_next ? -p_cl : p_fl);
                    neg2_next = n_fl[SW-1];
                    n2_next   = NW'(neg2_next ? -n_cl : n_fl);
                end
                else
                begin
                    neg1_next = n_fl[SW-1];
                    n1_next   = NW'(neg1_next ? -n_cl : n_fl);
                    neg2_next = p_fl[SW-1];
                    n2_next   = NW'(neg2_next ? -p_cl : p_fl);
                end
            end
            KIND_COMPLEX:
            begin
                neg1_next = kx[SW-1];
                n1_next   = NW'(kabs);
                neg2_next = 1'b0;
                n2_next   = NW'(qx);
            end
            default:
            begin
                neg1_next = kx[SW-1];
                n1_next   = NW'(kabs);
                neg2_next = kx[SW-1];
                n2_next   = NW'(kabs);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= 1'b0;
        end
        else if (en)
        begin
            nv_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= n1_next;
            n2_reg   <= n2_next;
            neg1_reg <= neg1_next;
            neg2_reg <= neg2_next;
            nk_reg   <= s_kind;
            nm_reg   <= s_m;
        end
    end

    qrs_div #(
        .NW (NW),
        .MW (MW),
        .TW (3)
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nv_reg),
        .num       (n1_reg),
        .den       (nm_reg),
        .tag_in    ({nk_reg, neg1_reg}),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .tag_out   (d1_tag)
    );

    qrs_div #(
        .NW (NW),
        .MW (MW),
        .TW (3)
    ) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nv_reg),
        .num       (n2_reg),
        .den       (nm_reg),
        .tag_in    ({nk_reg, neg2_reg}),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .tag_out   (d2_tag)
    );

    always_comb
    begin
        fctrl.valid = d1_valid && d2_valid;
        fctrl.kind  = kind_t'(d1_tag[2:1]);
        fctrl.neg1  = d1_tag[0];
        fctrl.neg2  = d2_tag[0];
    end

    qrs_finish #(
        .NW        (NW),
        .FRAC_BITS (FRAC_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fctrl),
        .mag1      (d1_quo),
        .mag2      (d2_quo),
        .en        (en),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (res)
    );

    assign s_axis_tready = en;
    assign m_axis_tdata  = OTW'({res.second, res.first});
    assign m_axis_tuser  = res.kind;

endmodule

[rtl/qrs_disc.sv]
// Front end: registers coefficients, forms products, discriminant and class.
// Depends on qrs_pkg.
module qrs_disc
    import qrs_pkg::*;
#(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [COEF_BITS-1:0]          coef_a,
    input  logic signed [COEF_BITS-1:0]          coef_b,
    input  logic signed [COEF_BITS-1:0]          coef_c,
    output logic                                 out_valid,
    output logic        [2*COEF_BITS+3:0]        d_abs,
    output kind_t                                kind,
    output logic                                 a_neg,
    output logic signed [COEF_BITS+FRAC_BITS:0]  k_val,
    output logic        [COEF_BITS:0]            m_val
);

    localparam int PW = 2*COEF_BITS + 3;
    localparam int DW = 2*COEF_BITS + 4;
    localparam int KW = COEF_BITS + FRAC_BITS + 1;
    localparam int MW = COEF_BITS + 1;

    logic                          v1_reg, v2_reg, v3_reg;
    logic signed [COEF_BITS-1:0]   a1_reg, b1_reg, c1_reg, a2_reg, b2_reg;
    logic signed [2*COEF_BITS-1:0] bb_reg, ac_reg;
    logic signed [2*COEF_BITS-1:0] bb_next, ac_next;
    logic        [DW-1:0]          dabs_reg, dabs_next;
    kind_t                         kind_reg, kind_next;
    logic                          aneg_reg, aneg_next;
    logic signed [KW-1:0]          k_reg, k_next;
    logic        [MW-1:0]          m_reg, m_next;
    logic signed [PW-1:0]          d;
    logic signed [MW-1:0]          a_ext, b_ext, b_sel;

    always_comb
    begin
        bb_next   = b1_reg * b1_reg;
        ac_next   = a1_reg * c1_reg;
        d         = PW'(bb_reg) - (PW'(ac_reg) <<< 2);
        a_ext     = MW'(a2_reg);
        b_ext     = MW'(b2_reg);
        aneg_next = a2_reg[COEF_BITS-1];
        b_sel     = aneg_next ? b_ext : -b_ext;
        k_next    = KW'(b_sel) <<< FRAC_BITS;
        m_next    = MW'(aneg_next ? -a_ext : a_ext) << 1;
        dabs_next = DW'(d[PW-1] ? -d : d);
        if (a2_reg == '0)
        begin
            kind_next = KIND_NONE;
        end
        else if (d == '0)
        begin
            kind_next = KIND_DOUBLE;
        end
        else if (!d[PW-1])
        begin
            kind_next = KIND_REAL;
        end
        else
        begin
            kind_next = KIND_COMPLEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= coef_a;
            b1_reg   <= coef_b;
            c1_reg   <= coef_c;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            bb_reg   <= bb_next;
            ac_reg   <= ac_next;
            dabs_reg <= dabs_next;
            kind_reg <= kind_next;
            aneg_reg <= aneg_next;
            k_reg    <= k_next;
            m_reg    <= m_next;
        end
    end

    assign out_valid = v3_reg;
    assign d_abs     = dabs_reg;
    assign kind      = kind_reg;
    assign a_neg     = aneg_reg;
    assign k_val     = k_reg;
    assign m_val     = m_reg;

endmodule

[rtl/qrs_sqrt.sv]
// Pipelined digit-by-digit square root, one result bit per stage.
// Root of d * 4^FRAC_BITS with exactness flag; tag rides along. No dependencies.
module qrs_sqrt
#(
    parameter int SP        = 34,
    parameter int FRAC_BITS = 16,
    parameter int TW        = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [2*(SP-FRAC_BITS)-1:0] d_in,
    input  logic [TW-1:0]            tag_in,
    output logic                     out_valid,
    output logic [SP-1:0]            root,
    output logic                     exact,
    output logic [TW-1:0]            tag_out
);

    localparam int DW = 2*(SP-FRAC_BITS);
    localparam int RW = SP + 2;

    logic          vld_reg  [SP];
    logic [RW-1:0] rem_reg  [SP];
    logic [SP-1:0] root_reg [SP];
    logic [DW-1:0] d_reg    [SP];
    logic [TW-1:0] tag_reg  [SP];

    for (genvar j = 0; j < SP; j++)
    begin : g_stage
        localparam int I = SP - 1 - j;
        logic          v_in;
        logic [RW-1:0] r_in, r_cat, trial, rem_next;
        logic [SP-1:0] q_in, root_next;
        logic [DW-1:0] dd_in;
        logic [TW-1:0] t_in;
        logic [1:0]    pair;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign r_in  = '0;
            assign q_in  = '0;
            assign dd_in = d_in;
            assign t_in  = tag_in;
        end
        else
        begin : g_next
            assign v_in  = vld_reg[j-1];
            assign r_in  = rem_reg[j-1];
            assign q_in  = root_reg[j-1];
            assign dd_in = d_reg[j-1];
            assign t_in  = tag_reg[j-1];
        end

        if (I >= FRAC_BITS)
        begin : g_pair
            assign pair = dd_in[2*(I-FRAC_BITS)+1 -: 2];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        always_comb
        begin
            r_cat     = {r_in[RW-3:0], pair};
            trial     = {q_in, 2'b01};
            ge        = (r_cat >= trial);
            rem_next  = ge ? (r_cat - trial) : r_cat;
            root_next = {q_in[SP-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                d_reg[j]    <= dd_in;
                tag_reg[j]  <= t_in;
            end
        end
    end

    assign out_valid = vld_reg[SP-1];
    assign root      = root_reg[SP-1];
    assign exact     = (rem_reg[SP-1] == '0);
    assign tag_out   = tag_reg[SP-1];

endmodule

[rtl/qrs_div.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Divisor and tag ride along with the dividend. No dependencies.
module qrs_div
#(
    parameter int NW = 35,
    parameter int MW = 17,
    parameter int TW = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [MW-1:0] den,
    input  logic [TW-1:0] tag_in,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [TW-1:0] tag_out
);

    logic          vld_reg [NW];
    logic [MW-1:0] rem_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [MW-1:0] den_reg [NW];
    logic [TW-1:0] tag_reg [NW];

    for (genvar j = 0; j < NW; j++)
    begin : g_stage
        logic          v_in, ge;
        logic [MW-1:0] r_in, m_in, rem_next;
        logic [MW:0]   r2, diff;
        logic [NW-1:0] q_in, n_in, quo_next;
        logic [TW-1:0] t_in;

        if (j == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign q_in = '0;
            assign n_in = num;
            assign m_in = den;
            assign t_in = tag_in;
        end
        else
        begin : g_next
            assign v_in = vld_reg[j-1];
            assign r_in = rem_reg[j-1];
            assign q_in = quo_reg[j-1];
            assign n_in = num_reg[j-1];
            assign m_in = den_reg[j-1];
            assign t_in = tag_reg[j-1];
        end

        always_comb
        begin
            r2       = {r_in, n_in[NW-1-j]};
            diff     = r2 - {1'b0, m_in};
            ge       = (r2 >= {1'b0, m_in});
            rem_next = ge ? diff[MW-1:0] : r2[MW-1:0];
            quo_next = {q_in[NW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                quo_reg[j] <= quo_next;
                num_reg[j] <= n_in;
                den_reg[j] <= m_in;
                tag_reg[j] <= t_in;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quo       = quo_reg[NW-1];
    assign tag_out   = tag_reg[NW-1];

endmodule

[rtl/qrs_finish.sv]
// Saturation, near-zero band, sign and the output register with skid stage.
// Depends on qrs_pkg. Drives the pipeline advance enable.
module qrs_finish
    import qrs_pkg::*;
#(
    parameter int NW        = 35,
    parameter int FRAC_BITS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  fin_ctrl_t       ctrl,
    input  logic [NW-1:0]   mag1,
    input  logic [NW-1:0]   mag2,
    output logic            en,
    output logic            out_valid,
    input  logic            out_ready,
    output result_t         result
);

    localparam int XW = ((NW > OUT_BITS) ? NW : OUT_BITS) + 1;
    localparam logic [XW-1:0] LIM_NEG = XW'(1) << (OUT_BITS - 1);
    localparam logic [XW-1:0] LIM_POS = LIM_NEG - XW'(1);
    localparam logic [XW-1:0] ZBAND   = XW'((64'd1 << FRAC_BITS) / ZERO_BAND_SCALE);

    function automatic logic signed [OUT_BITS-1:0] fin(input logic [NW-1:0] mag,
                                                       input logic neg);
        logic [XW-1:0] mx;
        logic [XW-1:0] lim;
        logic [XW-1:0] sv;
        mx  = XW'(mag);
        lim = neg ? LIM_NEG : LIM_POS;
        if (mx > lim)
        begin
            mx = lim;
        end
        if (mx <= ZBAND)
        begin
            mx = '0;
        end
        sv = neg ? -mx : mx;
        return sv[OUT_BITS-1:0];
    endfunction

    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    result_t fin_res;
    logic    in_fire;

    always_comb
    begin
        fin_res.kind   = ctrl.kind;
        fin_res.first  = fin(mag1, ctrl.neg1);
        fin_res.second = fin(mag2, ctrl.neg2);
        if (ctrl.kind == KIND_NONE)
        begin
            fin_res.first  = '0;
            fin_res.second = '0;
        end
    end

    assign en      = !skid_valid_reg;
    assign in_fire = ctrl.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (in_fire)
            begin
                skid_reg <= fin_res;
            end
        end
        else
        begin
            out_reg <= skid_valid_reg ? skid_reg : fin_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

[rtl/qrs_checker.sv]
// Port-level checker for quadratic_root_solver, bound to the top level.
// Depends on qrs_pkg and quadratic_root_solver_defines.svh.
`include "quadratic_root_solver_defines.svh"

module qrs_checker
    import qrs_pkg::*;
#(
    parameter int COEF_BITS = 16
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    // coef_a, coef_b, coef_c, zero fill
    input logic [8*((3*COEF_BITS+7)/8)-1:0]   s_axis_tdata,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    // first_value, second_value, zero fill
    input logic [8*((2*OUT_BITS+7)/8)-1:0]    m_axis_tdata,
    // root_kind
    input logic [1:0]                         m_axis_tuser
);

    `QRS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `QRS_ASSERT_IMP(a_stall_only_full, !s_axis_tready, m_axis_tvalid)

    `QRS_ASSERT_IMP(a_none_zero, m_axis_tvalid && m_axis_tuser == KIND_NONE,
        m_axis_tdata == '0)

    `QRS_ASSERT_IMP(a_double_equal, m_axis_tvalid && m_axis_tuser == KIND_DOUBLE,
        m_axis_tdata[OUT_BITS-1:0] == m_axis_tdata[2*OUT_BITS-1:OUT_BITS])

    `QRS_ASSERT_IMP(a_imag_nonneg, m_axis_tvalid && m_axis_tuser == KIND_COMPLEX,
        !m_axis_tdata[2*OUT_BITS-1])

endmodule

bind quadratic_root_solver qrs_checker #(.COEF_BITS(COEF_BITS)) u_qrs_checker (.*);
